FILE: rtl/hsv_area_trace_classifier_defines.svh
// ---------------------------------------------------------------------------
// hsv_area_trace_classifier_defines
// Assertion macros used by the classifier top level.
// ---------------------------------------------------------------------------
`ifndef HSV_AREA_TRACE_CLASSIFIER_DEFINES_SVH
`define HSV_AREA_TRACE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define HSVATC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hsvatc: same-cycle check failed");

// next-cycle implication
`define HSVATC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hsvatc: next-cycle check failed");

`endif

FILE: rtl/hsvatc_pkg.sv
// ---------------------------------------------------------------------------
// hsvatc_pkg
// Types and constants of the HSV area classifier.
// ---------------------------------------------------------------------------
package hsvatc_pkg;

    localparam int AREA_COUNT = 8;   // cells in the chain, indexed 0..7

    localparam logic [11:0] ONE_Q = 12'd4095;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PIX  = 1'b1;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_RANGE = 2'd1;
    localparam logic [1:0] MODE_TURN  = 2'd2;
    localparam logic [1:0] MODE_LINE  = 2'd3;

    typedef struct packed {
        logic        func;
        logic [2:0]  area_index;
        logic [1:0]  area_mode;
        logic [11:0] hue_low;
        logic [11:0] hue_high;
        logic [11:0] area_thickness;
        logic [11:0] cut_slope;
        logic [11:0] cut_intercept;
        logic [35:0] target_rgb;
        logic [11:0] pix_hue;
        logic [11:0] pix_sat;
        logic [11:0] pix_val;
    } t_in_beat;

    typedef struct packed {
        logic        matched;
        logic [11:0] out_red;
        logic [11:0] out_green;
        logic [11:0] out_blue;
    } t_out_beat;

    // pixel travelling down the chain with the first match so far
    typedef struct packed {
        logic        valid;
        logic [11:0] hue;
        logic [11:0] sat;
        logic [11:0] val;
        logic [23:0] sv;
        logic        matched;
        logic [35:0] rgb;
    } t_pix_beat;

endpackage

FILE: rtl/hsvatc_front.sv
// ---------------------------------------------------------------------------
// hsvatc_front
// Chain entry: registers the pixel, forms s*v, seeds the result as white.
// ---------------------------------------------------------------------------
module hsvatc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_take,
    input  hsvatc_pkg::t_in_beat i_in,
    output hsvatc_pkg::t_pix_beat o_pix
);
    import hsvatc_pkg::*;

    t_pix_beat r_pix;
    t_pix_beat n_pix;

    always_comb begin
        n_pix         = r_pix;
        n_pix.valid   = i_take;
        n_pix.hue     = i_in.pix_hue;
        n_pix.sat     = i_in.pix_sat;
        n_pix.val     = i_in.pix_val;
        n_pix.sv      = {12'd0, i_in.pix_sat} * {12'd0, i_in.pix_val};
        n_pix.matched = 1'b0;
        n_pix.rgb     = {ONE_Q, ONE_Q, ONE_Q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix.valid <= 1'b0;
        end else if (i_adv) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

FILE: rtl/hsvatc_cell.sv
// ---------------------------------------------------------------------------
// hsvatc_cell
// One area entry and its two-stage match test; first match down the chain wins.
// ---------------------------------------------------------------------------
module hsvatc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_wr_en,
    input  hsvatc_pkg::t_in_beat  i_in,
    input  hsvatc_pkg::t_pix_beat i_pix,
    output hsvatc_pkg::t_pix_beat o_pix,
    output logic                  o_busy
);
    import hsvatc_pkg::*;

    // area entry
    logic [1:0]  r_mode;
    logic [11:0] r_lo, r_hi, r_thick, r_len, r_icp;
    logic [35:0] r_rgb;

    // stage A: products and flags
    t_pix_beat          r_pa;
    logic               r_en, r_line, r_pre_ok;
    logic [35:0]        r_lhs;
    logic signed [26:0] r_rhs_base;
    // stage B: decided pixel
    t_pix_beat          r_pb;

    logic               n_line, n_pre_ok, w_hue_ok;
    logic [11:0]        w_len_c;
    logic [35:0]        n_lhs;
    logic signed [13:0] w_diff;
    logic signed [26:0] n_rhs_base;
    logic signed [39:0] w_rhs, w_lhs_s;
    logic               w_cmp, w_hit;
    t_pix_beat          n_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
        end else if (i_wr_en) begin
            r_mode <= i_in.area_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_lo    <= i_in.hue_low;
            r_hi    <= i_in.hue_high;
            r_thick <= i_in.area_thickness;
            r_len   <= i_in.cut_slope;
            r_icp   <= i_in.cut_intercept;
            r_rgb   <= i_in.target_rgb;
        end
    end

    always_comb begin
        if (r_lo < r_hi) begin
            w_hue_ok = (i_pix.hue >= r_lo) && (i_pix.hue <= r_hi);
        end else if (r_hi < r_lo) begin
            w_hue_ok = (i_pix.hue >= r_lo) || (i_pix.hue <= r_hi);
        end else begin
            w_hue_ok = (r_mode == MODE_TURN) || (i_pix.hue == r_lo);
        end
        n_line = (r_mode == MODE_LINE);
        if (n_line) begin
            n_pre_ok = r_thick >= i_pix.val;
        end else begin
            n_pre_ok = w_hue_ok && (r_thick >= (ONE_Q - i_pix.sat));
        end
        w_len_c    = ONE_Q - r_len;
        n_lhs      = {24'd0, w_len_c} * {12'd0, i_pix.sv};
        w_diff     = $signed({2'b00, ONE_Q}) - $signed({2'b00, i_pix.val})
                     - $signed({2'b00, r_icp});
        n_rhs_base = 27'(w_diff) * $signed({15'd0, r_len});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa.valid <= 1'b0;
        end else if (i_adv) begin
            r_pa       <= i_pix;
            r_en       <= (r_mode != MODE_OFF);
            r_line     <= n_line;
            r_pre_ok   <= n_pre_ok;
            r_lhs      <= n_lhs;
            r_rhs_base <= n_rhs_base;
        end
    end

    // black side when (1-L)*s*v < (1-v-I)*L*4095; a zero slope never cuts
    always_comb begin
        w_rhs   = (40'(r_rhs_base) <<< 12) - 40'(r_rhs_base);
        w_lhs_s = $signed({4'd0, r_lhs});
        w_cmp   = w_lhs_s < w_rhs;
        if (r_line) begin
            w_hit = r_pre_ok && ((r_pa.sv == 24'd0) || w_cmp);
        end else begin
            w_hit = r_pre_ok && (r_pa.sv != 24'd0) && !w_cmp;
        end
        n_pb = r_pa;
        if (!r_pa.matched && r_en && w_hit) begin
            n_pb.matched = 1'b1;
            n_pb.rgb     = r_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb.valid <= 1'b0;
        end else if (i_adv) begin
            r_pb <= n_pb;
        end
    end

    assign o_pix  = r_pb;
    assign o_busy = r_pa.valid | r_pb.valid;

endmodule

FILE: rtl/hsv_area_trace_classifier.sv
// ---------------------------------------------------------------------------
// hsv_area_trace_classifier
// HSV pixel classifier: a chain of area cells, first matching area wins.
// ---------------------------------------------------------------------------
//  channel | dir | handshake                 | beat
//  --------+-----+---------------------------+------------------------------
//  in      | in  | i_in_valid / o_in_ready   | t_in_beat: area load or pixel
//  out     | out | o_out_valid / i_out_ready | t_out_beat: match and colour
//
//  A pixel beat enters the front stage, then passes two registers per cell
//  before its result lands in the output register; pixels stream at one per
//  cycle while the output is not stalled. A load beat waits until the chain
//  holds no pixel, then writes its cell.
//  Synchronous reset disables every area in the cycle after it is applied.
//  A stalled output register freezes the whole chain and drops o_in_ready.
// ---------------------------------------------------------------------------
`include "hsv_area_trace_classifier_defines.svh"

module hsv_area_trace_classifier (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  hsvatc_pkg::t_in_beat   i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output hsvatc_pkg::t_out_beat  o_out
);
    import hsvatc_pkg::*;

    t_pix_beat             w_link [AREA_COUNT+1];
    logic [AREA_COUNT-1:0] w_busy;
    logic [AREA_COUNT-1:0] w_wr;
    logic                  w_adv, w_empty, w_accept, w_take, w_load;

    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    // whole chain moves when the output register is free or being drained
    assign w_adv    = !r_out_valid || i_out_ready;
    assign w_empty  = !w_link[0].valid && (w_busy == '0);
    // loads wait for an empty chain so no pixel in flight sees a new entry
    assign o_in_ready = w_adv && ((i_in.func == FUNC_PIX) || w_empty);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_take   = w_accept && (i_in.func == FUNC_PIX);
    assign w_load   = w_accept && (i_in.func == FUNC_LOAD);

    hsvatc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_take  (w_take),
        .i_in    (i_in),
        .o_pix   (w_link[0])
    );

    for (genvar k = 0; k < AREA_COUNT; k++) begin : g_cell
        // indexes past the chain match no cell and are dropped
        assign w_wr[k] = w_load && (32'(i_in.area_index) == 32'(k));

        hsvatc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_wr_en (w_wr[k]),
            .i_in    (i_in),
            .i_pix   (w_link[k]),
            .o_pix   (w_link[k+1]),
            .o_busy  (w_busy[k])
        );
    end

    // unmatched pixels keep the white seeded at the front
    always_comb begin
        n_out.matched   = w_link[AREA_COUNT].matched;
        n_out.out_red   = w_link[AREA_COUNT].rgb[35:24];
        n_out.out_green = w_link[AREA_COUNT].rgb[23:12];
        n_out.out_blue  = w_link[AREA_COUNT].rgb[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_link[AREA_COUNT].valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a load only ever lands on an empty chain
    `HSVATC_ASSERT_NOW(a_load_empty, w_load, w_empty)
    // a held result blocks every input beat
    `HSVATC_ASSERT_NOW(a_stall_blocks, r_out_valid && !i_out_ready, !o_in_ready)
    // an accepted pixel shows up in the front stage next cycle
    `HSVATC_ASSERT_NEXT(a_pix_enters, w_take, w_link[0].valid)
    // no-match results are white
    `HSVATC_ASSERT_NOW(a_white, r_out_valid && !r_out.matched,
        (r_out.out_red == ONE_Q) && (r_out.out_green == ONE_Q) && (r_out.out_blue == ONE_Q))

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hsv_area_trace_classifier. Area loads and pixel
// beats go in over a valid/ready channel. A scoreboard keeps its own copy of
// the area table and the expected colour of every accepted pixel. Each output
// beat is checked field by field, in order, across several idle and stall
// mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import hsvatc_pkg::*;

    // pixel path: front stage, two registers per cell, output register
    localparam int PIPE_DEPTH      = 2 * AREA_COUNT + 2;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TIMEOUT_CYCLES  = 400000;

    // scoreboard copy of one area table entry
    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] hue_lo;
        logic [11:0] hue_hi;
        logic [11:0] thick;
        logic [11:0] slope;
        logic [11:0] icp;
    } area_shape_t;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_ready = 1'b0;
    t_in_beat  i_in        = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out;

    hsv_area_trace_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    area_shape_t area_shapes [AREA_COUNT];
    logic [35:0] area_colours[AREA_COUNT];
    t_out_beat   pending_colours[$];     // expected results, oldest first

    int unsigned send_idle_pct   = 0;    // chance per cycle that the sender idles
    int unsigned stall_pct       = 0;    // chance per cycle that the receiver stalls
    int unsigned hold_request    = 0;    // set by a test, taken by the receiver
    int unsigned hold_left       = 0;
    int unsigned hold_cycles_run = 0;
    int unsigned errors          = 0;
    int unsigned results_seen    = 0;
    int unsigned matches_seen    = 0;
    int unsigned loads_seen      = 0;

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Black side of the diagonal cut: s*v == 0 always counts as black. A zero
    // line length never does. Otherwise (1-L)*s*v < (1-v-I)*L, scaled by 4095.
    function automatic bit on_dark_side(logic [11:0] s, logic [11:0] v,
                                        logic [11:0] len, logic [11:0] icp);
        longint one, sl, vl, ll, il, prod;
        one  = ONE_Q;
        sl   = s;
        vl   = v;
        ll   = len;
        il   = icp;
        prod = sl * vl;
        if (prod == 0) return 1'b1;
        if (ll == 0) return 1'b0;
        return ((one - ll) * prod) < ((one - vl - il) * ll * one);
    endfunction

    function automatic bit area_hit(area_shape_t a, logic [11:0] h,
                                    logic [11:0] s, logic [11:0] v);
        if (a.mode == MODE_OFF) return 1'b0;
        if (a.mode == MODE_LINE) begin
            if (a.thick < v) return 1'b0;
            if (v != 0 && s != 0 && !on_dark_side(s, v, a.slope, a.icp)) return 1'b0;
            return 1'b1;
        end
        // hue: plain range, wrap-around, or equal bounds (exact or full turn)
        if (a.hue_lo < a.hue_hi) begin
            if (h < a.hue_lo || h > a.hue_hi) return 1'b0;
        end else if (a.hue_hi < a.hue_lo) begin
            if (h > a.hue_hi && h < a.hue_lo) return 1'b0;
        end else if (a.mode == MODE_RANGE && h != a.hue_lo) begin
            return 1'b0;
        end
        if (a.thick < ONE_Q - s) return 1'b0;
        if (v == 0 || s == 0) return 1'b0;
        if (on_dark_side(s, v, a.slope, a.icp)) return 1'b0;
        return 1'b1;
    endfunction

    // first matching area in index order wins, white when none does
    function automatic t_out_beat classify_pixel(logic [11:0] h, logic [11:0] s,
                                                 logic [11:0] v);
        t_out_beat r;
        r.matched   = 1'b0;
        r.out_red   = ONE_Q;
        r.out_green = ONE_Q;
        r.out_blue  = ONE_Q;
        for (int i = 0; i < AREA_COUNT; i++) begin
            if (area_hit(area_shapes[i], h, s, v)) begin
                r.matched   = 1'b1;
                r.out_red   = area_colours[i][35:24];
                r.out_green = area_colours[i][23:12];
                r.out_blue  = area_colours[i][11:0];
                return r;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: input beats update the table copy or queue an expectation,
    // output beats are checked against the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_colours.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, o_out);
                end else begin
                    want = pending_colours.pop_front();
                    check_field("matched", 12'(want.matched), 12'(o_out.matched));
                    check_field("out_red", want.out_red, o_out.out_red);
                    check_field("out_green", want.out_green, o_out.out_green);
                    check_field("out_blue", want.out_blue, o_out.out_blue);
                    results_seen++;
                    if (want.matched) matches_seen++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (i_in.func == FUNC_LOAD) begin
                    loads_seen++;
                    if (i_in.area_index < AREA_COUNT) begin
                        area_shapes[i_in.area_index] = '{i_in.area_mode, i_in.hue_low,
                            i_in.hue_high, i_in.area_thickness, i_in.cut_slope,
                            i_in.cut_intercept};
                        area_colours[i_in.area_index] = i_in.target_rgb;
                    end
                end else begin
                    pending_colours.push_back(
                        classify_pixel(i_in.pix_hue, i_in.pix_sat, i_in.pix_val));
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            hold_cycles_run++;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Q0.12 value that lands on the ends of the range now and then
    function automatic logic [11:0] rand_q12();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return ONE_Q;
            2:       return 12'($urandom_range(0, 15));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // mostly real hues, sometimes past 3600 up to the full 12 bits
    function automatic logic [11:0] rand_hue();
        if ($urandom_range(0, 99) < 85) return 12'($urandom_range(0, 3600));
        return 12'($urandom_range(0, 4095));
    endfunction

    // every field random, so the fields a beat ignores toggle as well
    function automatic t_in_beat noise_beat();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return t_in_beat'(raw[$bits(t_in_beat)-1:0]);
    endfunction

    function automatic t_in_beat load_beat(logic [2:0] idx, logic [1:0] mode,
                                           logic [11:0] lo, logic [11:0] hi,
                                           logic [11:0] thick, logic [11:0] slope,
                                           logic [11:0] icp, logic [35:0] rgb);
        t_in_beat b;
        b                = noise_beat();
        b.func           = FUNC_LOAD;
        b.area_index     = idx;
        b.area_mode      = mode;
        b.hue_low        = lo;
        b.hue_high       = hi;
        b.area_thickness = thick;
        b.cut_slope      = slope;
        b.cut_intercept  = icp;
        b.target_rgb     = rgb;
        return b;
    endfunction

    function automatic t_in_beat pixel_beat(logic [11:0] h, logic [11:0] s,
                                            logic [11:0] v);
        t_in_beat b;
        b         = noise_beat();
        b.func    = FUNC_PIX;
        b.pix_hue = h;
        b.pix_sat = s;
        b.pix_val = v;
        return b;
    endfunction

    function automatic t_in_beat random_area_beat();
        logic [63:0] rgb;
        logic [11:0] lo, hi, thick, slope;
        rgb   = {$urandom, $urandom};
        lo    = rand_hue();
        hi    = ($urandom_range(0, 9) == 0) ? lo : rand_hue();
        thick = ($urandom_range(0, 3) == 0) ? ONE_Q : rand_q12();
        slope = ($urandom_range(0, 9) == 0) ? 12'd0 : rand_q12();
        return load_beat(3'($urandom_range(0, AREA_COUNT - 1)), 2'($urandom_range(0, 3)),
                         lo, hi, thick, slope, rand_q12(), rgb[35:0]);
    endfunction

    // Two thirds of the pixels are aimed at an area of the table: hue inside its
    // range, half the time saturation above its thickness floor, and for a black
    // line half the time a value under its thickness. The rest are plain noise.
    function automatic t_in_beat random_pixel_beat();
        area_shape_t a;
        logic [11:0] h, s, v;
        if ($urandom_range(0, 2) == 0) return pixel_beat(rand_hue(), rand_q12(), rand_q12());
        a = area_shapes[$urandom_range(0, AREA_COUNT - 1)];
        if (a.hue_lo <= a.hue_hi) begin
            h = 12'($urandom_range(a.hue_lo, a.hue_hi));
        end else if ($urandom_range(0, 1) == 0) begin
            h = 12'($urandom_range(a.hue_lo, 4095));
        end else begin
            h = 12'($urandom_range(0, a.hue_hi));
        end
        s = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(ONE_Q - a.thick, ONE_Q))
                                        : rand_q12();
        v = (a.mode == MODE_LINE && $urandom_range(0, 1) == 0)
            ? 12'($urandom_range(0, a.thick)) : rand_q12();
        return pixel_beat(h, s, v);
    endfunction

    // Offer one beat and return at the edge where it is taken. Valid is
    // dropped only while idling, so each step sees one assignment at most.
    task automatic send_beat(t_in_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // stop offering and wait until every queued pixel has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_colours.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // all areas disabled after reset: every pixel comes back white
    task automatic test_empty_table();
        send_beat(pixel_beat(12'd0, 12'd0, 12'd0));
        send_beat(pixel_beat(12'hFFF, ONE_Q, ONE_Q));
        drain_results();
    endtask

    task automatic test_black_line();
        send_beat(load_beat(3'd0, MODE_LINE, 12'd0, 12'd0, 12'd2000, 12'd2048,
                            12'd1000, 36'h123_456_789));
        send_beat(pixel_beat(12'd500, ONE_Q, 12'd0));      // zero value
        send_beat(pixel_beat(12'd500, 12'd100, 12'd2001)); // thicker than allowed
        send_beat(pixel_beat(12'd500, 12'd0, 12'd1500));   // zero saturation
        send_beat(pixel_beat(12'd500, 12'd3000, 12'd1800)); // decided by the cut
        send_beat(load_beat(3'd0, MODE_OFF, 12'd0, 12'd0, 12'd2000, 12'd2048,
                            12'd1000, 36'h123_456_789));
        drain_results();
    endtask

    task automatic test_colour_areas();
        // plain range with zero line length: the cut never blacks out a nonzero s*v
        send_beat(load_beat(3'd1, MODE_RANGE, 12'd100, 12'd200, ONE_Q, 12'd0, 12'd0,
                            36'hFFF_000_FFF));
        send_beat(pixel_beat(12'd100, ONE_Q, ONE_Q));
        send_beat(pixel_beat(12'd201, ONE_Q, ONE_Q));
        send_beat(pixel_beat(12'd150, 12'd0, ONE_Q));
        send_beat(pixel_beat(12'd150, ONE_Q, 12'd0));
        // wrap-around range, checked past 3600 and behind the earlier area
        send_beat(load_beat(3'd2, MODE_RANGE, 12'd3500, 12'd100, ONE_Q, ONE_Q, ONE_Q,
                            36'h000_FFF_000));
        send_beat(pixel_beat(12'd3600, ONE_Q, ONE_Q));
        send_beat(pixel_beat(12'hFFF, 12'd4000, 12'd3000));
        send_beat(pixel_beat(12'd100, ONE_Q, ONE_Q));
        // equal bounds, full turn, zero thickness needs full saturation
        send_beat(load_beat(3'd3, MODE_TURN, 12'd777, 12'd777, 12'd0, 12'd100, 12'd0,
                            36'hABC_DEF_012));
        send_beat(pixel_beat(12'd2000, ONE_Q, ONE_Q));
        // equal bounds, exact hue only
        send_beat(load_beat(3'd4, MODE_RANGE, 12'd900, 12'd900, ONE_Q, 12'd0, 12'd0,
                            36'h000_000_000));
        send_beat(pixel_beat(12'd900, 12'd4000, 12'd2000));
        send_beat(pixel_beat(12'd901, 12'd4000, 12'd2000));
        // last entry as a catch-all black line for dark pixels
        send_beat(load_beat(3'd7, MODE_LINE, 12'd0, ONE_Q, ONE_Q, ONE_Q, 12'd0,
                            36'hFFF_FFF_FFF));
        send_beat(pixel_beat(12'd3000, 12'd100, 12'd100));
        drain_results();
    endtask

    // mixed loads and pixels, with a full drain halfway through
    task automatic run_random(int unsigned count, int unsigned idle, int unsigned stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int unsigned n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            if ($urandom_range(0, 99) < 15) send_beat(random_area_beat());
            else send_beat(random_pixel_beat());
        end
        drain_results();
    endtask

    // output held off for a long stretch while pixels keep coming: the chain
    // fills, o_in_ready drops, and the sender has to wait it out
    task automatic test_hold_off();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = HOLD_OFF_CYCLES;
        repeat (3 * PIPE_DEPTH) send_beat(random_pixel_beat());
        drain_results();
    endtask

    initial begin
        foreach (area_shapes[i]) begin
            area_shapes[i]  = '0;
            area_colours[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_black_line();
        test_colour_areas();
        run_random(250, 0, 0);
        run_random(220, 54, 0);
        test_hold_off();
        run_random(220, 0, 54);
        run_random(210, 18, 18);

        // let anything stray leave the pipe before judging
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        $display("Ran %0d area loads and %0d pixel results (%0d matched) over four idle mixes,",
                 loads_seen, results_seen, matches_seen);
        $display("plus a %0d-cycle output hold-off; %0d mismatches.", hold_cycles_run, errors);
        if (errors == 0 && pending_colours.size() == 0) begin
            $display("PASS hsv_area_trace_classifier");
        end else begin
            $display("FAIL hsv_area_trace_classifier");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 4);
        $display("%0t: timeout with %0d results outstanding", $time, pending_colours.size());
        $display("FAIL hsv_area_trace_classifier");
        $finish;
    end

endmodule
